@@ rtl/pcg_pkg.sv @@
// Shared types, constants and helpers for the PCM channel gain block.
// Depends on nothing; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package pcg_pkg;

    localparam int MAX_CHANNELS   = 8;
    localparam int GAIN_FRAC_BITS = 15;

    localparam int CH_W       = 3;
    localparam int COUNT_W    = 4;
    localparam int SAMPLE_W   = 32;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int GSEL_W   = $clog2(2 * CFG_DATA_W);
    localparam int CGAIN_W  = GAIN_FRAC_BITS + 1;
    localparam int GPROD_W  = 2 * GAIN_FRAC_BITS + 1;
    localparam int MAG_W    = SAMPLE_W;
    localparam int SV_W     = MAG_W + 1;
    localparam int PROD_W   = MAG_W + GPROD_W;
    localparam int SCALED_W = PROD_W - 2 * GAIN_FRAC_BITS;
    localparam int VAL_W    = SCALED_W + 1;

    localparam logic [CGAIN_W-1:0] GAIN_UNITY = CGAIN_W'(1) << GAIN_FRAC_BITS;

    localparam logic [SV_W-1:0]  U8_OFFSET  = SV_W'(128);
    localparam logic [VAL_W-1:0] U8_OFS_VAL = VAL_W'(128);
    localparam logic signed [VAL_W-1:0] U8_MIN  = VAL_W'(0);
    localparam logic signed [VAL_W-1:0] U8_MAX  = VAL_W'(255);
    localparam logic signed [VAL_W-1:0] S16_MIN = -VAL_W'(32768);
    localparam logic signed [VAL_W-1:0] S16_MAX = VAL_W'(32767);
    localparam logic signed [VAL_W-1:0] S24_MIN = -VAL_W'(8388608);
    localparam logic signed [VAL_W-1:0] S24_MAX = VAL_W'(8388607);
    localparam logic signed [VAL_W-1:0] S32_MIN = -VAL_W'(64'd2147483648);
    localparam logic signed [VAL_W-1:0] S32_MAX = VAL_W'(64'd2147483647);

    localparam logic [1:0]            RST_FORMAT = 2'd1;
    localparam logic [COUNT_W-1:0]    RST_COUNT  = COUNT_W'(2);
    localparam logic [GAIN_W-1:0]     RST_MASTER = 16'h8000;
    localparam logic [CFG_DATA_W-1:0] RST_GAINS  = 64'h8000_8000_8000_8000;

    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S24 = 2'd2,
        FMT_S32 = 2'd3
    } fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT     = 3'd0,
        CFG_COUNT      = 3'd1,
        CFG_MASTER     = 3'd2,
        CFG_GAINS_LOW  = 3'd3,
        CFG_GAINS_HIGH = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        fmt_t                  fmt;
        logic [COUNT_W-1:0]    count;
        logic [GAIN_W-1:0]     master;
        logic [CFG_DATA_W-1:0] gains_low;
        logic [CFG_DATA_W-1:0] gains_high;
    } cfg_t;

    typedef struct packed {
        fmt_t                fmt;
        logic                bad;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] raw;
        logic                neg;
        logic [MAG_W-1:0]    mag;
        logic [CGAIN_W-1:0]  master_g;
        logic [CGAIN_W-1:0]  chan_g;
    } front_t;

    typedef struct packed {
        fmt_t                fmt;
        logic                bad;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] raw;
        logic                neg;
        logic [MAG_W-1:0]    mag;
        logic [GPROD_W-1:0]  gain;
    } mid_t;

    typedef struct packed {
        fmt_t                fmt;
        logic                bad;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] raw;
        logic                neg;
        logic [SCALED_W-1:0] scaled;
    } back_t;

    function automatic logic [SAMPLE_W-1:0] fmt_mask(input fmt_t f);
        logic [SAMPLE_W-1:0] m;
        unique case (f)
            FMT_U8:  m = 32'h0000_00FF;
            FMT_S16: m = 32'h0000_FFFF;
            FMT_S24: m = 32'h00FF_FFFF;
            FMT_S32: m = 32'hFFFF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [CGAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
        logic [CGAIN_W-1:0] r;
        if (GAIN_W'(g) > GAIN_W'(GAIN_UNITY))
            r = GAIN_UNITY;
        else
            r = CGAIN_W'(g);
        return r;
    endfunction

endpackage

@@ rtl/pcm_channel_gain_saturate.sv @@
// Top level of the PCM channel gain and saturation block.
// Depends on pcg_pkg, pcg_cfg_regs, pcg_decode, pcg_scale, pcg_finish.
`timescale 1ns / 1ps

// One sample per clock: a sample is taken at every edge with start high and
// busy low, and busy is always low. Each sample gives one result beat, passing
// the decode, mid, back and finish registers, shown for one cycle with done high;
// there is no backpressure, so the sink must take every beat. The four stages are
// decode and gain select, gain product, sample-times-gain multiply (32 x 31
// bits), and sign restore with clipping. Configuration writes take effect at the
// next edge and are meant for when no sample is in flight.
module pcm_channel_gain_saturate (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [pcg_pkg::CH_W-1:0]       channel,
    input  logic [pcg_pkg::SAMPLE_W-1:0]   sample_in,
    output logic                           done,
    output logic [pcg_pkg::SAMPLE_W-1:0]   sample_out,
    output logic [pcg_pkg::CH_W-1:0]       channel_echo,
    output logic                           bad_channel,
    input  logic                           cfg_we,
    input  logic [pcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pcg_pkg::*;

    cfg_t   cfg;
    logic   s1_valid;
    front_t s1_data;
    logic   s3_valid;
    back_t  s3_data;
    logic   accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    pcg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcg_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .channel   (channel),
        .sample_in (sample_in),
        .cfg       (cfg),
        .out_valid (s1_valid),
        .out_data  (s1_data)
    );

    pcg_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .out_valid (s3_valid),
        .out_data  (s3_data)
    );

    pcg_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s3_valid),
        .in_data      (s3_data),
        .done         (done),
        .sample_out   (sample_out),
        .channel_echo (channel_echo),
        .bad_channel  (bad_channel)
    );

endmodule

@@ rtl/pcg_cfg_regs.sv @@
// Configuration register bank: format, channel count, master and channel gains.
// Depends on pcg_pkg.
`timescale 1ns / 1ps

module pcg_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pcg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcg_pkg::CFG_DATA_W-1:0] cfg_data,
    output pcg_pkg::cfg_t                 cfg
);
    import pcg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FORMAT:     cfg_next.fmt        = fmt_t'(cfg_data[1:0]);
                CFG_COUNT:      cfg_next.count      = cfg_data[COUNT_W-1:0];
                CFG_MASTER:     cfg_next.master     = cfg_data[GAIN_W-1:0];
                CFG_GAINS_LOW:  cfg_next.gains_low  = cfg_data;
                CFG_GAINS_HIGH: cfg_next.gains_high = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fmt        <= fmt_t'(RST_FORMAT);
            cfg_reg.count      <= RST_COUNT;
            cfg_reg.master     <= RST_MASTER;
            cfg_reg.gains_low  <= RST_GAINS;
            cfg_reg.gains_high <= RST_GAINS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pcg_decode.sv @@
// Stage 1: sample decode to sign and magnitude, channel check, gain select and clamp.
// Depends on pcg_pkg.
`timescale 1ns / 1ps

module pcg_decode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [pcg_pkg::CH_W-1:0]     channel,
    input  logic [pcg_pkg::SAMPLE_W-1:0] sample_in,
    input  pcg_pkg::cfg_t                cfg,
    output logic                         out_valid,
    output pcg_pkg::front_t              out_data
);
    import pcg_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    front_t data_reg;
    front_t data_next;

    logic signed [SV_W-1:0] sv;
    logic [SV_W-1:0]        sv_neg;
    logic [2*CFG_DATA_W-1:0] gains_all;
    logic [GSEL_W-1:0]      gsel;

    always_comb
    begin
        unique case (cfg.fmt)
            FMT_U8:  sv = SV_W'(sample_in[7:0]) - U8_OFFSET;
            FMT_S16: sv = SV_W'($signed(sample_in[15:0]));
            FMT_S24: sv = SV_W'($signed(sample_in[23:0]));
            FMT_S32: sv = SV_W'($signed(sample_in[31:0]));
            default: sv = SV_W'($signed(sample_in[31:0]));
        endcase
        sv_neg    = -sv;
        gains_all = {cfg.gains_high, cfg.gains_low};
        gsel      = GSEL_W'(channel) << $clog2(GAIN_W);

        data_next.fmt      = cfg.fmt;
        data_next.bad      = ({1'b0, channel} >= cfg.count)
                          || ({1'b0, channel} >= COUNT_W'(MAX_CHANNELS));
        data_next.ch       = channel;
        data_next.raw      = sample_in & fmt_mask(cfg.fmt);
        data_next.neg      = sv[SV_W-1];
        data_next.mag      = sv[SV_W-1] ? sv_neg[MAG_W-1:0] : sv[MAG_W-1:0];
        data_next.master_g = clamp_gain(cfg.master);
        data_next.chan_g   = clamp_gain(gains_all[gsel +: GAIN_W]);
        valid_next         = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/pcg_scale.sv @@
// Stages 2 and 3: combined gain product, then magnitude times gain with the
// fraction bits dropped (truncation toward zero). Depends on pcg_pkg.
`timescale 1ns / 1ps

module pcg_scale (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  pcg_pkg::front_t in_data,
    output logic            out_valid,
    output pcg_pkg::back_t  out_data
);
    import pcg_pkg::*;

    logic   mid_valid_reg;
    logic   mid_valid_next;
    mid_t   mid_reg;
    mid_t   mid_next;
    logic   back_valid_reg;
    logic   back_valid_next;
    back_t  back_reg;
    back_t  back_next;

    logic [PROD_W-1:0] prod;

    always_comb
    begin
        mid_next.fmt   = in_data.fmt;
        mid_next.bad   = in_data.bad;
        mid_next.ch    = in_data.ch;
        mid_next.raw   = in_data.raw;
        mid_next.neg   = in_data.neg;
        mid_next.mag   = in_data.mag;
        mid_next.gain  = GPROD_W'(in_data.master_g) * GPROD_W'(in_data.chan_g);
        mid_valid_next = in_valid;
    end

    always_comb
    begin
        prod             = PROD_W'(mid_reg.mag) * PROD_W'(mid_reg.gain);
        back_next.fmt    = mid_reg.fmt;
        back_next.bad    = mid_reg.bad;
        back_next.ch     = mid_reg.ch;
        back_next.raw    = mid_reg.raw;
        back_next.neg    = mid_reg.neg;
        back_next.scaled = prod[PROD_W-1:2*GAIN_FRAC_BITS];
        back_valid_next  = mid_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg  <= 1'b0;
            back_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg  <= mid_valid_next;
            back_valid_reg <= back_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            mid_reg <= mid_next;
        if (mid_valid_reg)
            back_reg <= back_next;
    end

    assign out_valid = back_valid_reg;
    assign out_data  = back_reg;

endmodule

@@ rtl/pcg_finish.sv @@
// Stage 4: restore sign, offset, clip to the format's range, mask; output register.
// A bad channel passes its masked raw sample instead. Depends on pcg_pkg.
`timescale 1ns / 1ps

module pcg_finish (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  pcg_pkg::back_t               in_data,
    output logic                         done,
    output logic [pcg_pkg::SAMPLE_W-1:0] sample_out,
    output logic [pcg_pkg::CH_W-1:0]     channel_echo,
    output logic                         bad_channel
);
    import pcg_pkg::*;

    logic                done_reg;
    logic                done_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] sample_next;
    logic [CH_W-1:0]     ch_reg;
    logic                bad_reg;

    logic signed [VAL_W-1:0] mag_s;
    logic signed [VAL_W-1:0] v;
    logic signed [VAL_W-1:0] t;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] c;

    always_comb
    begin
        mag_s = $signed({1'b0, in_data.scaled});
        v     = in_data.neg ? -mag_s : mag_s;
        unique case (in_data.fmt)
            FMT_U8:
            begin
                t  = v + $signed(U8_OFS_VAL);
                lo = U8_MIN;
                hi = U8_MAX;
            end
            FMT_S16:
            begin
                t  = v;
                lo = S16_MIN;
                hi = S16_MAX;
            end
            FMT_S24:
            begin
                t  = v;
                lo = S24_MIN;
                hi = S24_MAX;
            end
            default:
            begin
                t  = v;
                lo = S32_MIN;
                hi = S32_MAX;
            end
        endcase

        priority if (t < lo)
            c = lo;
        else if (t > hi)
            c = hi;
        else
            c = t;

        if (in_data.bad)
            sample_next = in_data.raw;
        else
            sample_next = c[SAMPLE_W-1:0] & fmt_mask(in_data.fmt);
        done_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            sample_reg <= sample_next;
            ch_reg     <= in_data.ch;
            bad_reg    <= in_data.bad;
        end
    end

    assign done         = done_reg;
    assign sample_out   = sample_reg;
    assign channel_echo = ch_reg;
    assign bad_channel  = bad_reg;

endmodule

@@ rtl/pcg_checker.sv @@
// Port-level checks for pcm_channel_gain_saturate, bound to the top level.
// Depends on pcg_pkg.
`timescale 1ns / 1ps

module pcg_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [pcg_pkg::CH_W-1:0]     channel,
    input logic                         done,
    input logic [pcg_pkg::CH_W-1:0]     channel_echo
);
    import pcg_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##3 done)
        else $error("accepted sample gave no result beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result beat without a matching sample");

    a_channel_echo: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (channel_echo == $past(channel, 4)))
        else $error("channel echo does not match");

endmodule

bind pcm_channel_gain_saturate pcg_checker u_pcg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .channel      (channel),
    .done         (done),
    .channel_echo (channel_echo)
);
